[hw/rtl/fsts_pkg.sv]
// Package: shared types and constants of the fair share task scheduler.
package fsts_pkg;

  localparam int MaxTasks   = 16;
  localparam int PrioLevels = 10;
  localparam int IdW        = $clog2(MaxTasks);
  localparam int PrioW      = 4;
  localparam int CntW       = $clog2(MaxTasks + 1);
  localparam logic [31:0] IdealReset = 32'd20;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_ENQ     = 3'd1,
    MODE_DEQ     = 3'd2,
    MODE_TICK    = 3'd3,
    MODE_CHECK   = 3'd4,
    MODE_NONE5   = 3'd5,
    MODE_NONE6   = 3'd6,
    MODE_NONE7   = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_SCAN,
    ST_POST,
    ST_FINAL,
    ST_OUT
  } state_e;

  // scan unit control and result
  typedef struct packed {
    logic start;
  } scan_ctl_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [IdW-1:0]  idx;
  } scan_res_t;

  function automatic logic wrap_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

[hw/rtl/fsts_scan.sv]
// Sequential scan for the queued task with the smallest vruntime.
module fsts_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fsts_pkg::scan_ctl_t        ctl_i,
  input  logic [fsts_pkg::MaxTasks-1:0] queued_i,
  input  logic [31:0]                vr_i [fsts_pkg::MaxTasks],
  input  logic [31:0]                st_i [fsts_pkg::MaxTasks],
  output fsts_pkg::scan_res_t        res_o
);
  import fsts_pkg::*;

  logic           busy_q, busy_d;
  logic [IdW-1:0] i_q, i_d;
  logic           found_q, found_d;
  logic [IdW-1:0] best_q, best_d;
  logic           done_q, done_d;
  logic [31:0]    dv;
  logic           better;

  always_comb begin
    dv = vr_i[i_q] - vr_i[best_q];
    better = dv[31] || (dv == '0 && st_i[i_q] < st_i[best_q]);
  end

  always_comb begin
    busy_d  = busy_q;
    i_d     = i_q;
    found_d = found_q;
    best_d  = best_q;
    done_d  = 1'b0;
    if (ctl_i.start) begin
      busy_d  = 1'b1;
      i_d     = '0;
      found_d = 1'b0;
      best_d  = '0;
    end else if (busy_q) begin
      if (queued_i[i_q] && (!found_q || better)) begin
        best_d  = i_q;
        found_d = 1'b1;
      end
      if (i_q == IdW'(MaxTasks - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        i_d = i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      i_q     <= '0;
      found_q <= 1'b0;
      best_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      i_q     <= i_d;
      found_q <= found_d;
      best_q  <= best_d;
      done_q  <= done_d;
    end
  end

  assign res_o.done  = done_q;
  assign res_o.found = found_q;
  assign res_o.idx   = best_q;

endmodule

[hw/rtl/fair_share_task_scheduler_top.sv]
// Top level: fair share task scheduler with run queue, sequencer and APB port.
//
//   channel  | dir | handshake             | payload
//   s_axis   | in  | tvalid/tready         | tdata: mode,task_id,prio,prev_valid,prev_task,now
//   m_axis   | out | tvalid/tready         | tdata: preempt,first_valid,first_task,min_vr,count,error
//   apb      | in  | psel/penable/pready   | slice length at address 0
//
// A request is accepted in IDLE; OP applies the operation and starts the scan over all task
// entries, SCAN waits for the scan to finish, and OUT registers the result.
// A dequeue or tick that runs the minimum update goes on through POST and FINAL to rescan.
// Reset clears task state and status except the enqueue stamps; the scan unit holds no tables.
// The output register holds a result until taken; the next request is accepted only after
// the result has been taken.
module fair_share_task_scheduler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] mode, [6:3] task_id, [10:7] prio, [11] prev_valid, [15:12] prev_task,
  // [47:16] now
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] preempt, [1] first_valid, [5:2] first_task, [37:6] min_vruntime_out,
  // [42:38] queued_count, [43] error
  output logic [47:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fsts_pkg::*;

  logic [31:0] ideal_q;
  logic [31:0] vr_q [MaxTasks];
  logic [PrioW-1:0] pr_q [MaxTasks];
  logic [31:0] last_q [MaxTasks];
  logic [31:0] start_q [MaxTasks];
  logic [31:0] stamp_q [MaxTasks];
  logic [MaxTasks-1:0] queued_q;
  logic [31:0] minvr_q;
  logic [IdW-1:0] cur_q;
  logic        curv_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0] order_q;

  state_e state_q, state_d;
  logic [2:0]  mode_q;
  logic [3:0]  id_q;
  logic [3:0]  prio_q;
  logic        pv_q;
  logic [3:0]  prev_q;
  logic [31:0] now_q;
  logic        err_q;
  logic        pre_q;
  logic        post_q;
  logic [47:0] out_q;
  logic        outv_q;

  scan_ctl_t scan_ctl;
  scan_res_t scan_res;

  fsts_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (scan_ctl),
    .queued_i (queued_q),
    .vr_i     (vr_q),
    .st_i     (stamp_q),
    .res_o    (scan_res)
  );

  assign pready = 1'b1;
  assign prdata = ideal_q;
  assign s_axis_tready = (state_q == ST_IDLE) && !outv_q;
  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = out_q;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  logic id_ok;
  assign id_ok = ({1'b0, id_q} < 5'(MaxTasks));
  logic [IdW-1:0] id;
  assign id = id_q[IdW-1:0];

  logic [31:0] elapsed, ran, lead, cand, fvr, prod, adv;
  always_comb begin
    elapsed = now_q - last_q[cur_q];
    ran     = last_q[cur_q] - start_q[cur_q];
    fvr     = vr_q[scan_res.idx];
    lead    = vr_q[cur_q] - fvr;
    prod    = 32'(({28'd0, pr_q[cur_q]} + 32'd1) * elapsed);
    cand    = curv_q ? vr_q[cur_q] : minvr_q;
    if (scan_res.found) begin
      if (!curv_q || wrap_lt(fvr, cand)) cand = fvr;
    end
    adv     = cand - minvr_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (acc) state_d = ST_OP;
      ST_OP:    state_d = ST_SCAN;
      ST_SCAN:  if (scan_res.done) state_d = post_q ? ST_POST : ST_OUT;
      ST_POST:  state_d = ST_FINAL;
      ST_FINAL: if (scan_res.done) state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_ctl.start = (state_q == ST_OP) || (state_q == ST_POST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ideal_q <= IdealReset;
      queued_q <= '0;
      minvr_q <= '0;
      cur_q   <= '0;
      curv_q  <= 1'b0;
      cnt_q   <= '0;
      order_q <= '0;
      outv_q  <= 1'b0;
      err_q   <= 1'b0;
      pre_q   <= 1'b0;
      post_q  <= 1'b0;
      for (int k = 0; k < MaxTasks; k++) begin
        vr_q[k]    <= '0;
        pr_q[k]    <= '0;
        last_q[k]  <= '0;
        start_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && paddr == 1'b0) ideal_q <= pwdata;
      if (outv_q && m_axis_tready) outv_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            mode_q <= s_axis_tdata[2:0];
            id_q   <= s_axis_tdata[6:3];
            prio_q <= s_axis_tdata[10:7];
            pv_q   <= s_axis_tdata[11];
            prev_q <= s_axis_tdata[15:12];
            now_q  <= s_axis_tdata[47:16];
            err_q  <= 1'b0;
            pre_q  <= 1'b0;
            post_q <= 1'b0;
          end
        end
        ST_OP: begin
          unique case (mode_e'(mode_q))
            MODE_INIT: if (id_ok) begin
              pr_q[id] <= (prio_q > 4'(PrioLevels - 1)) ? 4'(PrioLevels - 1) : prio_q;
              if (queued_q[id]) begin
                queued_q[id] <= 1'b0;
                cnt_q <= cnt_q - 1'b1;
              end
              vr_q[id] <= minvr_q;
              last_q[id] <= '0;
              start_q[id] <= '0;
            end
            MODE_ENQ: begin
              if (!id_ok || queued_q[id]) err_q <= 1'b1;
              else begin
                vr_q[id] <= minvr_q;
                stamp_q[id] <= order_q;
                order_q <= order_q + 1'b1;
                queued_q[id] <= 1'b1;
                cnt_q <= cnt_q + 1'b1;
              end
            end
            MODE_DEQ: begin
              if (!id_ok || !queued_q[id]) err_q <= 1'b1;
              else begin
                if (pv_q) begin
                  start_q[id] <= ({1'b0, prev_q} < 5'(MaxTasks)) ?
                                 last_q[prev_q[IdW-1:0]] : '0;
                  cur_q  <= id;
                  curv_q <= 1'b1;
                end else begin
                  start_q[id] <= now_q;
                end
                queued_q[id] <= 1'b0;
                cnt_q <= cnt_q - 1'b1;
                post_q <= 1'b1;
              end
            end
            MODE_TICK: begin
              if (curv_q && elapsed != '0) begin
                last_q[cur_q] <= now_q;
                vr_q[cur_q] <= vr_q[cur_q] + prod;
                post_q <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_SCAN: begin
          if (scan_res.done && !post_q && mode_e'(mode_q) == MODE_CHECK && curv_q) begin
            if (ran > ideal_q) pre_q <= 1'b1;
            else if (scan_res.found && !lead[31] && lead > ideal_q) pre_q <= 1'b1;
          end
          if (scan_res.done && post_q) begin
            if (adv != '0 && !adv[31]) minvr_q <= cand;
          end
        end
        ST_OUT: begin
          out_q  <= {4'd0, err_q, cnt_q, minvr_q,
                     scan_res.found ? scan_res.idx : 4'd0, scan_res.found, pre_q};
          outv_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
